// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted (active low)
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that also holds across reset
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/bcdk_pkg.sv -----
package bcdk_pkg;

    // stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 3;

    // result tdata field positions (lowest bit of each field)
    localparam int OF_PAYLOAD_BYTE  = 0;
    localparam int OF_KEYWORD       = 8;
    localparam int OF_SERVO_ONE     = 11;
    localparam int OF_SERVO_TWO     = 19;
    localparam int OF_CHECKSUM_OK   = 27;
    localparam int OF_RX_CHECKSUM   = 28;
    localparam int OF_CALC_CHECKSUM = 36;
    localparam int OF_LINE_COUNT    = 44;
    localparam int OF_BLOCK_NUMBER  = 59;
    localparam int M_TDATA_USED     = 75;

    // result tuser flag positions
    localparam int UF_PAYLOAD_VALID = 0;
    localparam int UF_BLOCK_DONE    = 1;
    localparam int UF_HEADER_DONE   = 2;

    // configuration register map (index selected by paddr[2])
    localparam int  APB_ADDR_W            = 3;
    localparam int  APB_DATA_W            = 32;
    localparam logic REG_DEFAULT_BLOCK_LEN = 1'b0;
    localparam logic [7:0] DEFAULT_BLOCK_LEN_RST = 8'd64;

    // header and checksum constants
    localparam logic [7:0] HDR_VALID_MARK = 8'd255;
    localparam logic [8:0] CSUM_MOD       = 9'd254;
    localparam logic [8:0] CSUM_MOD_X2    = 9'd508;
    localparam logic [7:0] CSUM_ZERO_AS   = 8'd254;
    localparam logic signed [16:0] LC_BIAS  = 17'sd100;
    localparam logic signed [16:0] LC_SCALE = 17'sd100;

    // servo positions
    localparam logic [7:0] SERVO_ONE_CENTER = 8'd90;
    localparam logic [7:0] SERVO_TWO_CENTER = 8'd120;
    localparam logic [7:0] SERVO_ONE_UP     = 8'd100;
    localparam logic [7:0] SERVO_ONE_DOWN   = 8'd80;
    localparam logic [7:0] SERVO_TWO_LOW    = 8'd110;
    localparam logic [7:0] SERVO_TWO_HIGH   = 8'd130;

    // keyword byte patterns, newest byte lowest
    localparam logic [15:0] KW_UP_PAT    = 16'h7570;
    localparam logic [7:0]  KW_RIGHT_R   = 8'h72;
    localparam logic [31:0] KW_RIGHT_PAT = 32'h69676874;
    localparam logic [31:0] KW_LEFT_PAT  = 32'h6C656674;
    localparam logic [31:0] KW_DOWN_PAT  = 32'h646F776E;

    typedef enum logic [2:0] {
        KW_NONE  = 3'd0,
        KW_UP    = 3'd1,
        KW_RIGHT = 3'd2,
        KW_LEFT  = 3'd3,
        KW_DOWN  = 3'd4
    } keyword_t;

    // framing phase: four header bytes, then blocks
    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_HDR2  = 3'd2,
        PH_HDR3  = 3'd3,
        PH_BLOCK = 3'd4
    } phase_t;

endpackage

// ----- hw/rtl/block_checksum_deframer_keywords_top.sv -----
// channel   | direction | ports                   | content
// ----------+-----------+-------------------------+------------------------------------
// s_axis    | in        | tvalid/tready/tdata/tuser | one received byte or a clear request
// m_axis    | out       | tvalid/tready/tdata/tuser | one result per input transaction
// apb       | in/out    | psel/penable/pwrite/...   | default block length register
//
// one transaction per cycle unless m_axis stalls: the byte is decoded by
// single-level logic from the framing state and enters the result register
// when accepted. the result register frees at the edge it is taken, so
// s_axis_tready follows m_axis_tready while a result is pending. synchronous
// active-low reset clears framing state, servos to center, block length to 64.
module block_checksum_deframer_keywords_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // apb configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bcdk_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bcdk_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bcdk_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bcdk_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [7:0] rx_byte
    input  logic [bcdk_pkg::S_TUSER_W-1:0]      s_axis_tuser,  // [0] mode
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] payload_byte, [10:8] keyword, [18:11] servo_one, [26:19] servo_two,
    // [27] checksum_ok, [35:28] received_checksum, [43:36] computed_checksum,
    // [58:44] line_count, [74:59] block_number, [79:75] zero
    output logic [bcdk_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // [0] payload_valid, [1] block_done, [2] header_done
    output logic [bcdk_pkg::M_TUSER_W-1:0]      m_axis_tuser
);
    import bcdk_pkg::*;

    // configuration register
    logic [7:0] default_len_reg;
    logic       cfg_write;

    // framing state
    phase_t      phase_reg, phase_next;
    logic [7:0]  first_hdr_reg, first_hdr_next;
    logic [7:0]  second_hdr_reg, second_hdr_next;
    logic [7:0]  block_len_reg, block_len_next;
    logic [7:0]  byte_in_block_reg, byte_in_block_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [31:0] recent_reg, recent_next;
    logic [7:0]  older_reg, older_next;
    logic [15:0] blocks_reg, blocks_next;
    logic [7:0]  servo_one_reg, servo_one_next;
    logic [7:0]  servo_two_reg, servo_two_next;

    // result register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [M_TUSER_W-1:0] m_user_reg, m_user_next;

    logic       s_accept;
    logic       clear_req;
    logic [7:0] rx_byte;

    // datapath helpers
    logic [8:0]         sum_wide;
    logic [7:0]         sum_mod;
    logic [7:0]         calc_csum;
    logic [31:0]        shifted;
    keyword_t           kw;
    logic signed [16:0] line_count_full;

    // result fields
    logic          r_payload_valid;
    logic [7:0]    r_payload_byte;
    keyword_t      r_keyword;
    logic          r_block_done;
    logic          r_checksum_ok;
    logic [7:0]    r_rx_csum;
    logic [7:0]    r_calc_csum;
    logic          r_header_done;
    logic [14:0]   r_line_count;

    assign clear_req     = s_axis_tuser[0];
    assign rx_byte       = s_axis_tdata[7:0];
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DEFAULT_BLOCK_LEN);
    assign prdata    = (paddr[2] == REG_DEFAULT_BLOCK_LEN)
                     ? {{(APB_DATA_W-8){1'b0}}, default_len_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_len_reg <= DEFAULT_BLOCK_LEN_RST;
        end else if (cfg_write) begin
            default_len_reg <= pwdata[7:0];
        end
    end

    // framing phase next state
    always_comb begin
        phase_next = phase_reg;
        if (clear_req) begin
            phase_next = PH_HDR0;
        end else begin
            unique case (phase_reg)
                PH_HDR0:  phase_next = PH_HDR1;
                PH_HDR1:  phase_next = PH_HDR2;
                PH_HDR2:  phase_next = PH_HDR3;
                PH_HDR3:  phase_next = PH_BLOCK;
                PH_BLOCK: phase_next = PH_BLOCK;
                default:  phase_next = PH_HDR0;
            endcase
        end
    end

    // running checksum mod 254 and keyword match on the shifted window
    always_comb begin
        sum_wide = {1'b0, running_sum_reg} + {1'b0, rx_byte};
        if (sum_wide >= CSUM_MOD_X2) begin
            sum_mod = '0;
        end else if (sum_wide >= CSUM_MOD) begin
            sum_mod = 8'(sum_wide - CSUM_MOD);
        end else begin
            sum_mod = sum_wide[7:0];
        end
        calc_csum = (running_sum_reg == 8'd0) ? CSUM_ZERO_AS : running_sum_reg;
        shifted   = {recent_reg[23:0], rx_byte};
        priority if (shifted[15:0] == KW_UP_PAT) begin
            kw = KW_UP;
        end else if (recent_reg[31:24] == KW_RIGHT_R && shifted == KW_RIGHT_PAT) begin
            kw = KW_RIGHT;
        end else if (shifted == KW_LEFT_PAT) begin
            kw = KW_LEFT;
        end else if (shifted == KW_DOWN_PAT) begin
            kw = KW_DOWN;
        end else begin
            kw = KW_NONE;
        end
        line_count_full = ($signed({9'b0, first_hdr_reg}) - LC_BIAS) * LC_SCALE
                        + ($signed({9'b0, second_hdr_reg}) - LC_BIAS);
    end

    // state update and result fields for one byte
    always_comb begin
        first_hdr_next     = first_hdr_reg;
        second_hdr_next    = second_hdr_reg;
        block_len_next     = block_len_reg;
        byte_in_block_next = byte_in_block_reg;
        running_sum_next   = running_sum_reg;
        recent_next        = recent_reg;
        older_next         = older_reg;
        blocks_next        = blocks_reg;
        servo_one_next     = servo_one_reg;
        servo_two_next     = servo_two_reg;

        r_payload_valid = 1'b0;
        r_payload_byte  = '0;
        r_keyword       = KW_NONE;
        r_block_done    = 1'b0;
        r_checksum_ok   = 1'b0;
        r_rx_csum       = '0;
        r_calc_csum     = '0;
        r_header_done   = 1'b0;
        r_line_count    = '0;

        if (clear_req) begin
            first_hdr_next     = '0;
            second_hdr_next    = '0;
            block_len_next     = default_len_reg;
            byte_in_block_next = '0;
            running_sum_next   = '0;
            recent_next        = '0;
            older_next         = '0;
            blocks_next        = '0;
            servo_one_next     = SERVO_ONE_CENTER;
            servo_two_next     = SERVO_TWO_CENTER;
        end else begin
            unique case (phase_reg)
                PH_HDR0: first_hdr_next  = rx_byte;
                PH_HDR1: second_hdr_next = rx_byte;
                PH_HDR2: recent_next     = {24'b0, rx_byte};
                PH_HDR3: begin
                    if (rx_byte == HDR_VALID_MARK) begin
                        block_len_next = recent_reg[7:0];
                        r_header_done  = 1'b1;
                        r_line_count   = line_count_full[14:0];
                    end else begin
                        block_len_next = default_len_reg;
                    end
                    recent_next        = '0;
                    older_next         = '0;
                    byte_in_block_next = '0;
                    running_sum_next   = '0;
                end
                PH_BLOCK: begin
                    if (byte_in_block_reg >= block_len_reg) begin
                        // checksum byte closes the block
                        r_block_done       = 1'b1;
                        r_checksum_ok      = (calc_csum == rx_byte);
                        r_rx_csum          = rx_byte;
                        r_calc_csum        = calc_csum;
                        blocks_next        = blocks_reg + 16'd1;
                        byte_in_block_next = '0;
                        running_sum_next   = '0;
                        recent_next        = '0;
                        older_next         = '0;
                    end else begin
                        // payload byte
                        older_next         = recent_reg[31:24];
                        recent_next        = shifted;
                        running_sum_next   = sum_mod;
                        byte_in_block_next = byte_in_block_reg + 8'd1;
                        r_payload_valid    = 1'b1;
                        r_payload_byte     = rx_byte;
                        r_keyword          = kw;
                        unique case (kw)
                            KW_UP: begin
                                servo_one_next = SERVO_ONE_UP;
                                servo_two_next = SERVO_TWO_LOW;
                            end
                            KW_RIGHT: begin
                                servo_one_next = SERVO_ONE_UP;
                                servo_two_next = SERVO_TWO_HIGH;
                            end
                            KW_LEFT: begin
                                servo_one_next = SERVO_ONE_DOWN;
                                servo_two_next = SERVO_TWO_LOW;
                            end
                            KW_DOWN: begin
                                servo_one_next = SERVO_ONE_DOWN;
                                servo_two_next = SERVO_TWO_HIGH;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // pack the result transaction
    always_comb begin
        m_data_next = '0;
        m_data_next[OF_PAYLOAD_BYTE  +: 8]  = r_payload_byte;
        m_data_next[OF_KEYWORD       +: 3]  = r_keyword;
        m_data_next[OF_SERVO_ONE     +: 8]  = servo_one_next;
        m_data_next[OF_SERVO_TWO     +: 8]  = servo_two_next;
        m_data_next[OF_CHECKSUM_OK]         = r_checksum_ok;
        m_data_next[OF_RX_CHECKSUM   +: 8]  = r_rx_csum;
        m_data_next[OF_CALC_CHECKSUM +: 8]  = r_calc_csum;
        m_data_next[OF_LINE_COUNT    +: 15] = r_line_count;
        m_data_next[OF_BLOCK_NUMBER  +: 16] = blocks_next;
        m_user_next = '0;
        m_user_next[UF_PAYLOAD_VALID] = r_payload_valid;
        m_user_next[UF_BLOCK_DONE]    = r_block_done;
        m_user_next[UF_HEADER_DONE]   = r_header_done;
    end

    // framing state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_HDR0;
            first_hdr_reg     <= '0;
            second_hdr_reg    <= '0;
            block_len_reg     <= DEFAULT_BLOCK_LEN_RST;
            byte_in_block_reg <= '0;
            running_sum_reg   <= '0;
            recent_reg        <= '0;
            older_reg         <= '0;
            blocks_reg        <= '0;
            servo_one_reg     <= SERVO_ONE_CENTER;
            servo_two_reg     <= SERVO_TWO_CENTER;
        end else if (s_accept) begin
            phase_reg         <= phase_next;
            first_hdr_reg     <= first_hdr_next;
            second_hdr_reg    <= second_hdr_next;
            block_len_reg     <= block_len_next;
            byte_in_block_reg <= byte_in_block_next;
            running_sum_reg   <= running_sum_next;
            recent_reg        <= recent_next;
            older_reg         <= older_next;
            blocks_reg        <= blocks_next;
            servo_one_reg     <= servo_one_next;
            servo_two_reg     <= servo_two_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ----- hw/rtl/bcdk_checker.sv -----
`include "assert_macros.svh"

module bcdk_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [bcdk_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bcdk_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input logic [bcdk_pkg::M_TUSER_W-1:0]   m_axis_tuser
);
    import bcdk_pkg::*;

    // a stalled result holds its payload
    `ASSERT_CLK_RST(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    // every accepted transaction shows up at the output in the next cycle
    `ASSERT_CLK_RST(a_accept_to_result, aclk, aresetn, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "accepted transaction gave no result")

    // a clear request returns centered servos, block count zero and no flags
    `ASSERT_CLK_RST(a_clear_result, aclk, aresetn, s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> m_axis_tdata[OF_SERVO_ONE +: 8] == SERVO_ONE_CENTER && m_axis_tdata[OF_SERVO_TWO +: 8] == SERVO_TWO_CENTER && m_axis_tdata[OF_BLOCK_NUMBER +: 16] == 16'd0 && m_axis_tuser == '0, "clear result wrong")

    // reset empties the result register
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind block_checksum_deframer_keywords_top bcdk_checker u_bcdk_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/block_checksum_deframer_keywords_top_tb.sv -----
module block_checksum_deframer_keywords_top_tb;
    import bcdk_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_ITEMS = 90;
    localparam logic [APB_ADDR_W-1:0] DFLT_LEN_ADDR = {REG_DEFAULT_BLOCK_LEN, 2'b00};

    // keyword text, newest byte lowest
    localparam logic [15:0] TXT_UP   = "up";
    localparam logic [7:0]  TXT_R    = "r";
    localparam logic [31:0] TXT_IGHT = "ight";
    localparam logic [31:0] TXT_LEFT = "left";
    localparam logic [31:0] TXT_DOWN = "down";

    // one deframed result, as carried on the result channel
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        keyword_t    keyword;
        logic [7:0]  servo_one;
        logic [7:0]  servo_two;
        logic        block_done;
        logic        checksum_ok;
        logic [7:0]  rx_csum;
        logic [7:0]  calc_csum;
        logic        header_done;
        logic [14:0] line_count;
        logic [15:0] block_number;
    } deframe_out_t;

    typedef struct packed {
        logic         mode;
        logic [7:0]   data;
        logic         typed;
        deframe_out_t res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // [7:0] rx_byte
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;   // [0] mode
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [7:0] payload_byte, [10:8] keyword, [18:11] servo_one, [26:19] servo_two,
    // [27] checksum_ok, [35:28] received_checksum, [43:36] computed_checksum,
    // [58:44] line_count, [74:59] block_number
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [0] payload_valid, [1] block_done, [2] header_done
    logic [M_TUSER_W-1:0] m_axis_tuser;

    // deframer model state
    logic [7:0]  cfg_block_len;
    phase_t      pr_phase;
    logic [7:0]  hdr_b0;
    logic [7:0]  hdr_b1;
    logic [7:0]  blk_len;
    logic [7:0]  blk_pos;
    logic [7:0]  blk_sum;
    logic [31:0] byte_window;
    logic [15:0] blocks_seen;
    logic [7:0]  servo1_pos;
    logic [7:0]  servo2_pos;

    deframe_out_t deframed_q [$];
    stim_row_t    directed_rows [24];
    string        kw_text [4] = '{"up", "right", "left", "down"};
    string        letters = "uprightlefdown";

    int  mismatches = 0;
    int  accepted_bytes = 0;
    int  cycle_count = 0;
    int  hold_req_cnt = 0;
    int  hold_seen = 0;
    int  stall_left = 0;
    logic calm = 1'b0;

    block_checksum_deframer_keywords_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void clear_deframer();
        pr_phase    = PH_HDR0;
        hdr_b0      = '0;
        hdr_b1      = '0;
        blk_len     = cfg_block_len;
        blk_pos     = '0;
        blk_sum     = '0;
        byte_window = '0;
        blocks_seen = '0;
        servo1_pos  = SERVO_ONE_CENTER;
        servo2_pos  = SERVO_TWO_CENTER;
    endfunction

    // advance the deframer by one byte or clear and return what it reports
    function automatic deframe_out_t deframe_byte(input logic clr, input logic [7:0] b);
        deframe_out_t r;
        logic [7:0]   five_back;
        keyword_t     kw;
        int           lc;
        r = '0;
        if (clr) begin
            clear_deframer();
        end else if (pr_phase != PH_BLOCK) begin
            case (pr_phase)
                PH_HDR0: hdr_b0 = b;
                PH_HDR1: hdr_b1 = b;
                PH_HDR2: byte_window = {24'd0, b};
                default: begin
                    if (b == 8'hFF) begin
                        lc = (int'(hdr_b0) - 100) * 100 + (int'(hdr_b1) - 100);
                        blk_len = byte_window[7:0];
                        r.header_done = 1'b1;
                        r.line_count = lc[14:0];
                    end else begin
                        blk_len = cfg_block_len;
                    end
                    byte_window = '0;
                    blk_pos = '0;
                    blk_sum = '0;
                end
            endcase
            pr_phase = phase_t'(pr_phase + 3'd1);
        end else if (blk_pos >= blk_len) begin
            // checksum byte closes the block
            r.block_done  = 1'b1;
            r.rx_csum     = b;
            r.calc_csum   = (blk_sum == 8'd0) ? 8'd254 : blk_sum;
            r.checksum_ok = (r.calc_csum == b);
            blocks_seen++;
            blk_pos = '0;
            blk_sum = '0;
            byte_window = '0;
        end else begin
            // payload byte: sum it and look for a keyword ending here
            five_back = byte_window[31:24];
            byte_window = {byte_window[23:0], b};
            blk_sum = 8'((int'(blk_sum) + int'(b)) % 254);
            blk_pos++;
            kw = KW_NONE;
            if (byte_window[15:0] == TXT_UP) kw = KW_UP;
            else if (five_back == TXT_R && byte_window == TXT_IGHT) kw = KW_RIGHT;
            else if (byte_window == TXT_LEFT) kw = KW_LEFT;
            else if (byte_window == TXT_DOWN) kw = KW_DOWN;
            case (kw)
                KW_UP: begin
                    servo1_pos = 8'd100;
                    servo2_pos = 8'd110;
                end
                KW_RIGHT: begin
                    servo1_pos = 8'd100;
                    servo2_pos = 8'd130;
                end
                KW_LEFT: begin
                    servo1_pos = 8'd80;
                    servo2_pos = 8'd110;
                end
                KW_DOWN: begin
                    servo1_pos = 8'd80;
                    servo2_pos = 8'd130;
                end
                default: ;
            endcase
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.keyword       = kw;
        end
        r.servo_one    = servo1_pos;
        r.servo_two    = servo2_pos;
        r.block_number = blocks_seen;
        return r;
    endfunction

    // result with centered servos and no payload
    function automatic deframe_out_t at_rest(input logic hdr, input logic [14:0] lc,
                                             input logic done, input logic ok,
                                             input logic [7:0] rx, input logic [7:0] comp,
                                             input logic [15:0] blk);
        deframe_out_t r;
        r = '0;
        r.servo_one    = SERVO_ONE_CENTER;
        r.servo_two    = SERVO_TWO_CENTER;
        r.header_done  = hdr;
        r.line_count   = lc;
        r.block_done   = done;
        r.checksum_ok  = ok;
        r.rx_csum      = rx;
        r.calc_csum    = comp;
        r.block_number = blk;
        return r;
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // offer one transaction, with an occasional gap before it
    task automatic send_item(input logic m, input logic [7:0] b);
        if (!calm && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        deframed_q.push_back(deframe_byte(m, b));
        accepted_bytes++;
    endtask

    // stop sending until every result is in, then let the pipeline settle
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write the default block length, then read it back
    task automatic apb_write(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DFLT_LEN_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("default_block_length readback", int'(value), int'(prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_block_len = value;
    endtask

    // usually a clear, a header, a few blocks with keyword-rich payload, sometimes noise after
    task automatic send_frame(input bit force_invalid);
        bit         hdr_ok;
        int         len;
        int         n_blocks;
        int         pick;
        string      word;
        logic [7:0] body [$];
        logic [7:0] csum;
        if ($urandom_range(9) != 0) send_item(1'b1, 8'($urandom));
        if (cfg_block_len <= 8'd16) hdr_ok = ($urandom_range(5) != 0);
        else hdr_ok = !force_invalid;
        if (!hdr_ok) len = int'(cfg_block_len);
        else if ($urandom_range(19) == 0) len = $urandom_range(40, 9);
        else len = $urandom_range(8);
        send_item(1'b0, 8'($urandom));
        send_item(1'b0, 8'($urandom));
        send_item(1'b0, hdr_ok ? 8'(len) : 8'($urandom));
        send_item(1'b0, hdr_ok ? 8'hFF : 8'($urandom_range(254)));
        n_blocks = (len > 16) ? 1 : $urandom_range(4, 1);
        repeat (n_blocks) begin
            body.delete();
            while (body.size() < len) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    word = kw_text[$urandom_range(3)];
                    for (int j = 0; j < word.len(); j++) body.push_back(word[j]);
                end else if (pick < 70) begin
                    body.push_back(letters[$urandom_range(letters.len() - 1)]);
                end else begin
                    body.push_back(8'($urandom));
                end
            end
            // a cut keyword at the end tries to run into the next block
            while (body.size() > len) void'(body.pop_back());
            csum = '0;
            foreach (body[i]) begin
                send_item(1'b0, body[i]);
                csum = 8'((int'(csum) + int'(body[i])) % 254);
            end
            if (csum == 8'd0) csum = 8'd254;
            if ($urandom_range(9) == 0) csum = 8'($urandom);
            send_item(1'b0, csum);
        end
        if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(5, 1)) send_item($urandom_range(9) == 0, 8'($urandom));
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seen != hold_req_cnt) begin
            hold_seen     <= hold_req_cnt;
            stall_left    <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(99) < 11) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        deframe_out_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (deframed_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end else begin
                want = deframed_q.pop_front();
                check_field("payload_valid", want.payload_valid,
                            m_axis_tuser[UF_PAYLOAD_VALID]);
                check_field("block_done", want.block_done, m_axis_tuser[UF_BLOCK_DONE]);
                check_field("header_done", want.header_done, m_axis_tuser[UF_HEADER_DONE]);
                check_field("payload_byte", want.payload_byte,
                            m_axis_tdata[OF_PAYLOAD_BYTE +: 8]);
                check_field("keyword", int'(want.keyword), m_axis_tdata[OF_KEYWORD +: 3]);
                check_field("servo_one", want.servo_one, m_axis_tdata[OF_SERVO_ONE +: 8]);
                check_field("servo_two", want.servo_two, m_axis_tdata[OF_SERVO_TWO +: 8]);
                check_field("checksum_ok", want.checksum_ok, m_axis_tdata[OF_CHECKSUM_OK]);
                check_field("received_checksum", want.rx_csum,
                            m_axis_tdata[OF_RX_CHECKSUM +: 8]);
                check_field("computed_checksum", want.calc_csum,
                            m_axis_tdata[OF_CALC_CHECKSUM +: 8]);
                check_field("line_count", int'($signed(want.line_count)),
                            int'($signed(m_axis_tdata[OF_LINE_COUNT +: 15])));
                check_field("block_number", want.block_number,
                            m_axis_tdata[OF_BLOCK_NUMBER +: 16]);
            end
        end
    end

    // stimulus
    initial begin
        int         p;
        int         start;
        bit         big_done;
        bit         go_big;
        bit         paused;
        bit         hold_sent;
        logic [7:0] cfg_plan [4];

        // directed: clears, header extremes, zero-length blocks, a keyword,
        // a keyword split by a checksum byte, an invalid header
        directed_rows = '{
            '{1'b1, 8'hFF, 1'b1,
              at_rest(1'b0, 15'd0, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0)},
            '{1'b0, 8'h00, 1'b0, deframe_out_t'(0)},
            '{1'b0, 8'h00, 1'b0, deframe_out_t'(0)},
            '{1'b0, 8'h00, 1'b0, deframe_out_t'(0)},
            '{1'b0, 8'hFF, 1'b1,
              at_rest(1'b1, -15'sd10100, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0)},
            '{1'b0, 8'hFE, 1'b1,
              at_rest(1'b0, 15'd0, 1'b1, 1'b1, 8'hFE, 8'hFE, 16'd1)},
            '{1'b0, 8'h00, 1'b1,
              at_rest(1'b0, 15'd0, 1'b1, 1'b0, 8'h00, 8'hFE, 16'd2)},
            '{1'b1, 8'h00, 1'b1,
              at_rest(1'b0, 15'd0, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0)},
            '{1'b0, 8'hFF, 1'b0, deframe_out_t'(0)},
            '{1'b0, 8'hFF, 1'b0, deframe_out_t'(0)},
            '{1'b0, 8'h02, 1'b0, deframe_out_t'(0)},
            '{1'b0, 8'hFF, 1'b1,
              at_rest(1'b1, 15'sd15655, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0)},
            '{1'b0, "u",   1'b0, deframe_out_t'(0)},
            '{1'b0, "p",   1'b0, deframe_out_t'(0)},
            '{1'b0, 8'hE5, 1'b0, deframe_out_t'(0)},
            '{1'b0, "a",   1'b0, deframe_out_t'(0)},
            '{1'b0, "u",   1'b0, deframe_out_t'(0)},
            '{1'b0, 8'h00, 1'b0, deframe_out_t'(0)},
            '{1'b0, "p",   1'b0, deframe_out_t'(0)},
            '{1'b1, 8'h7F, 1'b0, deframe_out_t'(0)},
            '{1'b0, 8'h01, 1'b0, deframe_out_t'(0)},
            '{1'b0, 8'h02, 1'b0, deframe_out_t'(0)},
            '{1'b0, 8'h03, 1'b0, deframe_out_t'(0)},
            '{1'b0, 8'hFE, 1'b0, deframe_out_t'(0)}
        };
        cfg_block_len = DEFAULT_BLOCK_LEN_RST;
        clear_deframer();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].mode, directed_rows[i].data);
            if (directed_rows[i].typed) deframed_q[deframed_q.size() - 1] = directed_rows[i].res;
        end

        // random frames under several block length settings
        cfg_plan  = '{8'd0, 8'd255, 8'd0, DEFAULT_BLOCK_LEN_RST};
        cfg_plan[2] = 8'($urandom_range(16, 1));
        hold_sent = 1'b0;
        paused    = 1'b0;
        for (p = 0; p < 4; p++) begin
            wait_drain();
            apb_write(cfg_plan[p]);
            calm <= (p == 2);
            start    = accepted_bytes;
            big_done = 1'b0;
            while (accepted_bytes - start < PHASE_ITEMS) begin
                go_big = !big_done && cfg_block_len > 8'd16 && accepted_bytes - start >= 20;
                if (go_big) big_done = 1'b1;
                send_frame(go_big);
                // long receiver hold-off while items keep coming
                if (p == 0 && !hold_sent) begin
                    hold_req_cnt <= hold_req_cnt + 1;
                    hold_sent = 1'b1;
                end
                // sender pause until all results are back
                if (p == 3 && !paused && accepted_bytes - start >= 50) begin
                    wait_drain();
                    paused = 1'b1;
                end
            end
        end

        wait_drain();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
